@@ src/amplifier_fault_supervisor_macros.svh @@
// Assertion macros used by the checker file of the amplifier fault supervisor.
`ifndef AMPLIFIER_FAULT_SUPERVISOR_MACROS_SVH
`define AMPLIFIER_FAULT_SUPERVISOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AFS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amplifier_fault_supervisor: property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define AFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amplifier_fault_supervisor: property failed");

`endif

@@ src/afs_pkg.sv @@
// Types, codes and reset values of the amplifier fault supervisor.
`default_nettype none

package afs_pkg;

  typedef enum logic [1:0] {
    OP_EVALUATE   = 2'd0,
    OP_MAINS_LOST = 2'd1,
    OP_SHUTDOWN   = 2'd2,
    OP_START      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_DC_LOW      = 3'd0,
    REG_DC_HIGH     = 3'd1,
    REG_BIAS_LOW    = 3'd2,
    REG_BIAS_HIGH   = 3'd3,
    REG_TEMP_LIMIT  = 3'd4,
    REG_ADC_ENABLE  = 3'd5,
    REG_TEMP_ENABLE = 3'd6
  } reg_idx_t;

  localparam logic [2:0] FK_NONE     = 3'd0;
  localparam logic [2:0] FK_MAINS    = 3'd1;
  localparam logic [2:0] FK_OFFSET_L = 3'd2;
  localparam logic [2:0] FK_OFFSET_R = 3'd3;
  localparam logic [2:0] FK_BIAS_L   = 3'd4;
  localparam logic [2:0] FK_BIAS_R   = 3'd5;
  localparam logic [2:0] FK_TEMP_L   = 3'd6;
  localparam logic [2:0] FK_TEMP_R   = 3'd7;

  localparam logic signed [15:0] DC_LOW_RESET     = -16'sd100;
  localparam logic signed [15:0] DC_HIGH_RESET    = 16'sd100;
  localparam logic signed [15:0] BIAS_LOW_RESET   = 16'sd0;
  localparam logic signed [15:0] BIAS_HIGH_RESET  = 16'sd250;
  localparam logic signed [8:0]  TEMP_LIMIT_RESET = 9'sd60;

  typedef struct packed {
    logic signed [15:0] dc_low;
    logic signed [15:0] dc_high;
    logic signed [15:0] bias_low;
    logic signed [15:0] bias_high;
    logic signed [8:0]  temp_limit;
    logic               adc_enable;
    logic               temp_enable;
  } afs_cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] offset_left;
    logic signed [15:0] offset_right;
    logic signed [15:0] current_left;
    logic signed [15:0] current_right;
    logic signed [8:0]  heat_left;
    logic signed [8:0]  heat_right;
  } afs_item_t;

  typedef struct packed {
    logic               left_ok;
    logic               right_ok;
    logic               fault_flag;
    logic [2:0]         fault_code;
    logic signed [15:0] fault_value;
    logic               power;
    logic               relay;
  } afs_state_t;

endpackage

`default_nettype wire

@@ src/afs_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none

interface afs_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] offset_left;
  logic signed [15:0] offset_right;
  logic signed [15:0] current_left;
  logic signed [15:0] current_right;
  logic signed [8:0]  heat_left;
  logic signed [8:0]  heat_right;

  modport source (
    output valid, op, offset_left, offset_right, current_left, current_right,
           heat_left, heat_right,
    input  ready
  );
  modport sink (
    input  valid, op, offset_left, offset_right, current_left, current_right,
           heat_left, heat_right,
    output ready
  );
endinterface

interface afs_result_if;
  logic               valid;
  logic               ready;
  logic               relays_closed;
  logic               power_enabled;
  logic               left_good;
  logic               right_good;
  logic               fault_latched;
  logic [2:0]         fault_kind;
  logic signed [15:0] fault_reading;

  modport source (
    output valid, relays_closed, power_enabled, left_good, right_good,
           fault_latched, fault_kind, fault_reading,
    input  ready
  );
  modport sink (
    input  valid, relays_closed, power_enabled, left_good, right_good,
           fault_latched, fault_kind, fault_reading,
    output ready
  );
endinterface

interface afs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/afs_step.sv @@
// Next-state logic of the supervisor for one op.
`default_nettype none

module afs_step import afs_pkg::*; (
  input  wire afs_cfg_t   regs,
  input  wire afs_item_t  item,
  input  wire afs_state_t st,
  output afs_state_t      st_next
);

  function automatic afs_state_t latch_check(afs_state_t s, logic fail, logic right_side,
                                             logic [2:0] code, logic signed [15:0] val);
    afs_state_t r;
    r = s;
    if (fail && (right_side ? s.right_ok : s.left_ok)) begin
      if (right_side) begin
        r.right_ok = 1'b0;
      end else begin
        r.left_ok = 1'b0;
      end
      r.fault_flag  = 1'b1;
      r.fault_code  = code;
      r.fault_value = val;
    end
    return r;
  endfunction

  logic               fail_ol, fail_or, fail_bl, fail_br, fail_tl, fail_tr;
  logic               adc_on, temp_on;
  logic               good_l, good_r;
  logic signed [15:0] heat_l_ext, heat_r_ext;

  assign fail_ol = (item.offset_left < regs.dc_low) || (item.offset_left > regs.dc_high);
  assign fail_or = (item.offset_right < regs.dc_low) || (item.offset_right > regs.dc_high);
  assign fail_bl = (item.current_left < regs.bias_low) || (item.current_left > regs.bias_high);
  assign fail_br = (item.current_right < regs.bias_low)
                   || (item.current_right > regs.bias_high);
  assign fail_tl = item.heat_left > regs.temp_limit;
  assign fail_tr = item.heat_right > regs.temp_limit;
  assign heat_l_ext = {{7{item.heat_left[8]}}, item.heat_left};
  assign heat_r_ext = {{7{item.heat_right[8]}}, item.heat_right};

  always_comb begin
    st_next = st;
    adc_on  = regs.adc_enable && !st.fault_flag;
    temp_on = 1'b0;
    good_l  = 1'b1;
    good_r  = 1'b1;
    unique case (item.op)
      OP_EVALUATE: begin
        if (adc_on) begin
          st_next = latch_check(st_next, fail_ol, 1'b0, FK_OFFSET_L, item.offset_left);
          st_next = latch_check(st_next, fail_or, 1'b1, FK_OFFSET_R, item.offset_right);
          st_next = latch_check(st_next, fail_bl, 1'b0, FK_BIAS_L, item.current_left);
          st_next = latch_check(st_next, fail_br, 1'b1, FK_BIAS_R, item.current_right);
          good_l  = !(fail_ol || fail_bl);
          good_r  = !(fail_or || fail_br);
        end
        temp_on = regs.temp_enable && !st_next.fault_flag;
        if (temp_on) begin
          st_next = latch_check(st_next, fail_tl, 1'b0, FK_TEMP_L, heat_l_ext);
          st_next = latch_check(st_next, fail_tr, 1'b1, FK_TEMP_R, heat_r_ext);
          good_l  = good_l && !fail_tl;
          good_r  = good_r && !fail_tr;
        end
        if (st_next.fault_flag) begin
          st_next.relay = 1'b0;
          st_next.power = 1'b0;
        end
        if (!(st_next.left_ok && st_next.right_ok && !st_next.fault_flag)) begin
          if (!st_next.left_ok && good_l) begin
            st_next.left_ok = 1'b1;
          end
          if (!st_next.right_ok && good_r) begin
            st_next.right_ok = 1'b1;
          end
          if (st_next.left_ok && st_next.right_ok && !st_next.fault_flag) begin
            st_next.relay = 1'b1;
          end
        end
      end
      OP_MAINS_LOST: begin
        if (st.left_ok && st.right_ok) begin
          st_next.relay      = 1'b0;
          st_next.power      = 1'b0;
          st_next.left_ok    = 1'b0;
          st_next.right_ok   = 1'b0;
          st_next.fault_flag = 1'b1;
          st_next.fault_code = FK_MAINS;
        end
      end
      OP_SHUTDOWN: begin
        st_next.relay    = 1'b0;
        st_next.power    = 1'b0;
        st_next.left_ok  = 1'b0;
        st_next.right_ok = 1'b0;
      end
      OP_START: begin
        if (!st.fault_flag) begin
          st_next.power = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/amplifier_fault_supervisor.sv @@
// Top level of the two-channel amplifier fault supervisor.
// The block takes one op per clock while the result slot is free or being taken, and
// returns one status result per op. An accepted op is held in an input register until the
// supervisor state is updated from it, and that state register is the result shown on the
// result channel, so each result passes through the input register and then the state
// register before it is shown. The input register and the state register advance together
// whenever the result slot is free or being taken. Register writes are always accepted
// and take effect at the edge of the transfer. A latched fault is cleared only by reset.
`default_nettype none

module amplifier_fault_supervisor import afs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  afs_cfg_if.sink        cfg,
  afs_item_if.sink       item,
  afs_result_if.source   result
);

  afs_cfg_t   regs;
  afs_item_t  item_q;
  logic       item_full;
  logic       out_valid;
  logic       advance;
  afs_state_t st;
  afs_state_t st_next;

  assign cfg.ready  = 1'b1;
  assign advance    = item_full && (!out_valid || result.ready);
  assign item.ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dc_low      <= DC_LOW_RESET;
      regs.dc_high     <= DC_HIGH_RESET;
      regs.bias_low    <= BIAS_LOW_RESET;
      regs.bias_high   <= BIAS_HIGH_RESET;
      regs.temp_limit  <= TEMP_LIMIT_RESET;
      regs.adc_enable  <= 1'b1;
      regs.temp_enable <= 1'b1;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_DC_LOW:      regs.dc_low      <= cfg.data;
        REG_DC_HIGH:     regs.dc_high     <= cfg.data;
        REG_BIAS_LOW:    regs.bias_low    <= cfg.data;
        REG_BIAS_HIGH:   regs.bias_high   <= cfg.data;
        REG_TEMP_LIMIT:  regs.temp_limit  <= cfg.data[8:0];
        REG_ADC_ENABLE:  regs.adc_enable  <= cfg.data[0];
        REG_TEMP_ENABLE: regs.temp_enable <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item.ready) begin
      item_full <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.op            <= op_t'(item.op);
      item_q.offset_left   <= item.offset_left;
      item_q.offset_right  <= item.offset_right;
      item_q.current_left  <= item.current_left;
      item_q.current_right <= item.current_right;
      item_q.heat_left     <= item.heat_left;
      item_q.heat_right    <= item.heat_right;
    end
  end

  afs_step u_step (
    .regs    (regs),
    .item    (item_q),
    .st      (st),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st        <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      st        <= st_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.relays_closed = st.relay;
  assign result.power_enabled = st.power;
  assign result.left_good     = st.left_ok;
  assign result.right_good    = st.right_ok;
  assign result.fault_latched = st.fault_flag;
  assign result.fault_kind    = st.fault_code;
  assign result.fault_reading = st.fault_value;

endmodule

`default_nettype wire

@@ src/afs_checker.sv @@
// Port-level assertions for the amplifier fault supervisor and their bind.
`default_nettype none
`include "amplifier_fault_supervisor_macros.svh"

module afs_checker import afs_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic       relays_closed,
  input wire logic       power_enabled,
  input wire logic       left_good,
  input wire logic       right_good,
  input wire logic       fault_latched,
  input wire logic [2:0] fault_kind
);

  `AFS_ASSERT(a_relays_need_both_good, result_valid && relays_closed, left_good && right_good && !fault_latched)
  `AFS_ASSERT(a_fault_kind_matches_flag, result_valid, (fault_kind == FK_NONE) == !fault_latched)
  `AFS_ASSERT(a_fault_keeps_power_off, result_valid && fault_latched, !power_enabled)
  `AFS_ASSERT_NEXT(a_fault_sticky, fault_latched, fault_latched)
  `AFS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)

endmodule

bind amplifier_fault_supervisor afs_checker u_afs_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .relays_closed (result.relays_closed),
  .power_enabled (result.power_enabled),
  .left_good     (result.left_good),
  .right_good    (result.right_good),
  .fault_latched (result.fault_latched),
  .fault_kind    (result.fault_kind)
);

`default_nettype wire
